/* src/dsei_pkg.sv */
// Shared types, codes and constants of the depth info SEI parser.
`timescale 1ns / 1ps
`default_nettype none
package dsei_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [63:0] field_value;
        logic        value_unspecified;
        logic        end_of_run;
    } t_out_word;

    typedef struct packed {
        logic        sign;
        logic [6:0]  exponent;
        logic [5:0]  mant_len;
        logic [31:0] mantissa;
    } t_conv_req;

    typedef enum logic [3:0] {
        PH_LEN, PH_NALSIZE, PH_NALTYPE, PH_SKIP, PH_PID, PH_PSIZE, PH_FLAGS,
        PH_REP_Z, PH_REP_S, PH_REF_Z, PH_REF_S, PH_SIGN, PH_EXP, PH_MLEN,
        PH_MANT, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_BYTE, SQ_BITS, SQ_CONV, SQ_FIN, SQ_DRAIN
    } t_seq_state;

    typedef enum logic [1:0] {
        CV_IDLE, CV_RUN
    } t_conv_state;

    localparam logic [2:0] K_FLAGS   = 3'd0;
    localparam logic [2:0] K_REP     = 3'd1;
    localparam logic [2:0] K_REF     = 3'd2;
    localparam logic [2:0] K_ZNEAR   = 3'd3;
    localparam logic [2:0] K_DMAX    = 3'd6;
    localparam logic [2:0] K_OUTCOME = 3'd7;

    localparam logic [2:0] OC_PARSED      = 3'd0;
    localparam logic [2:0] OC_SHORT       = 3'd1;
    localparam logic [2:0] OC_NOT_SEI     = 3'd2;
    localparam logic [2:0] OC_OTHER_PL    = 3'd3;
    localparam logic [2:0] OC_EARLY_END   = 3'd4;
    localparam logic [2:0] OC_GOLOMB_LONG = 3'd5;

    localparam logic [6:0]  NAL_TYPE_A    = 7'd39;
    localparam logic [6:0]  NAL_TYPE_B    = 7'd40;
    localparam logic [7:0]  DEPTH_PL_TYPE = 8'd177;
    localparam logic [5:0]  MAX_ZEROS     = 6'd31;
    localparam logic [6:0]  EXP_UNSPEC    = 7'd127;
    localparam logic [31:0] MIN_LENGTH    = 32'd4;
    localparam logic [10:0] EXP_BIAS_ADJ  = 11'd992;
    localparam logic [10:0] EXP_DENORM    = 11'd1024;

endpackage
`default_nettype wire

/* src/dsei_ifs.sv */
// Valid/ready channel interfaces for input bytes and parsed results.
`timescale 1ns / 1ps
`default_nettype none
interface dsei_in_if;
    logic                valid;
    logic                ready;
    dsei_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsei_out_if;
    logic                valid;
    logic                ready;
    dsei_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/depth_info_sei_parser_core.sv */
// Top level of the depth representation info SEI parser.
//
//  channel  dir  payload                                             flow
//  i_in     in   data_byte[7:0], last_byte                           valid/ready
//  o_out    out  field_kind[2:0], field_value[63:0],
//                value_unspecified, end_of_run                       valid/ready
//
// A header byte is handled in the byte step; a payload byte runs the
// one-bit-per-cycle parse loop, which halts while the shared shift unit
// converts a depth element; then the results drain from the 4-entry
// per-byte result buffer. Not ready while a byte is in work. Synchronous
// reset returns to waiting for the length header. A stalled output holds the
// sequencer in the drain step; the output register frees the input side.
`timescale 1ns / 1ps
`default_nettype none
module depth_info_sei_parser_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dsei_in_if.sink    i_in,
    dsei_out_if.source o_out
);
    import dsei_pkg::*;

    t_seq_state r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [1:0]  r_bytecnt, n_bytecnt;
    logic [31:0] r_len, n_len;
    logic [3:0]  r_flags, n_flags;
    logic [5:0]  r_zc, n_zc;
    logic [31:0] r_acc, n_acc;
    logic        r_sign, n_sign;
    logic [6:0]  r_exp, n_exp;
    logic [5:0]  r_mlen, n_mlen;
    logic [31:0] r_mant, n_mant;
    logic [5:0]  r_brem, n_brem;
    logic [1:0]  r_eidx, n_eidx;
    logic [2:0]  r_outcome, n_outcome;

    logic [7:0]  r_data;
    logic        r_last;
    logic [2:0]  r_bitidx;
    logic [2:0]  r_ckind;
    logic        r_cunsp;

    t_out_word   r_buf [4];
    logic [2:0]  r_bcnt;
    logic [1:0]  r_rd;
    logic        r_ovalid;
    t_out_word   r_oword;

    logic        w_bit;
    logic        w_push;
    t_out_word   w_push_word;
    logic        w_conv_start;
    t_conv_req   w_conv_req;
    logic        w_conv_done;
    logic [63:0] w_conv_bits;
    logic        w_is_bitphase;
    logic        w_load;
    logic        w_rd_last;
    logic [31:0] w_len_next;
    logic [31:0] w_gval;
    logic [2:0]  w_ne;
    t_out_word   w_head;

    function automatic logic [2:0] f_next_elem(input logic [3:0] flags, input logic [2:0] from);
        logic [2:0] res;
        res = 3'd4;
        for (int j = 3; j >= 0; j--) begin
            if (3'(j) >= from && flags[3 - j]) res = 3'(j);
        end
        return res;
    endfunction

    dsei_f64_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_req   (w_conv_req),
        .o_done  (w_conv_done),
        .o_bits  (w_conv_bits)
    );

    assign w_bit         = r_data[r_bitidx];
    assign w_is_bitphase = !(r_phase inside {PH_LEN, PH_NALSIZE, PH_NALTYPE, PH_SKIP,
                                             PH_PID, PH_PSIZE, PH_DONE});
    assign w_len_next    = {r_len[23:0], r_data};
    assign w_gval        = {r_acc[30:0], w_bit} - 32'd1;
    assign w_load        = (r_state == SQ_DRAIN) && (!r_ovalid || o_out.ready);
    assign w_rd_last     = ({1'b0, r_rd} + 3'd1) == r_bcnt;

    assign i_in.ready  = (r_state == SQ_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_oword;

    always_comb begin
        w_head            = r_buf[r_rd];
        w_head.end_of_run = w_rd_last;
    end

    // parse datapath
    always_comb begin
        n_phase   = r_phase;
        n_bytecnt = r_bytecnt;
        n_len     = r_len;
        n_flags   = r_flags;
        n_zc      = r_zc;
        n_acc     = r_acc;
        n_sign    = r_sign;
        n_exp     = r_exp;
        n_mlen    = r_mlen;
        n_mant    = r_mant;
        n_brem    = r_brem;
        n_eidx    = r_eidx;
        n_outcome = r_outcome;
        w_push       = 1'b0;
        w_push_word  = '0;
        w_conv_start = 1'b0;
        w_conv_req   = '{sign: r_sign, exponent: r_exp, mant_len: r_mlen,
                         mantissa: {r_mant[30:0], w_bit}};
        w_ne         = 3'd4;

        case (r_state)
            SQ_BYTE: begin
                case (r_phase)
                    PH_LEN: begin
                        n_len = w_len_next;
                        if (r_bytecnt == 2'd3) begin
                            n_bytecnt = 2'd0;
                            if (w_len_next <= MIN_LENGTH) begin
                                n_outcome = OC_SHORT;
                                n_phase   = PH_DONE;
                            end else begin
                                n_phase = PH_NALSIZE;
                            end
                        end else begin
                            n_bytecnt = r_bytecnt + 2'd1;
                        end
                    end
                    PH_NALSIZE: begin
                        if (r_bytecnt == 2'd3) begin
                            n_bytecnt = 2'd0;
                            n_phase   = PH_NALTYPE;
                        end else begin
                            n_bytecnt = r_bytecnt + 2'd1;
                        end
                    end
                    PH_NALTYPE: begin
                        if (r_data[7:1] inside {NAL_TYPE_A, NAL_TYPE_B}) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_outcome = OC_NOT_SEI;
                            n_phase   = PH_DONE;
                        end
                    end
                    PH_SKIP: n_phase = PH_PID;
                    PH_PID: begin
                        if (r_data == DEPTH_PL_TYPE) begin
                            n_phase = PH_PSIZE;
                        end else begin
                            n_outcome = OC_OTHER_PL;
                            n_phase   = PH_DONE;
                        end
                    end
                    PH_PSIZE: begin
                        n_flags = 4'd0;
                        n_brem  = 6'd4;
                        n_phase = PH_FLAGS;
                    end
                    default: ;
                endcase
            end
            SQ_BITS: begin
                case (r_phase)
                    PH_FLAGS: begin
                        n_flags = {r_flags[2:0], w_bit};
                        n_brem  = r_brem - 6'd1;
                        if (r_brem == 6'd1) begin
                            w_push      = 1'b1;
                            w_push_word = '{field_kind: K_FLAGS,
                                            field_value: {60'd0, r_flags[2:0], w_bit},
                                            value_unspecified: 1'b0, end_of_run: 1'b0};
                            n_zc    = 6'd0;
                            n_acc   = 32'd0;
                            n_phase = PH_REP_Z;
                        end
                    end
                    PH_REP_Z, PH_REF_Z: begin
                        if (!w_bit) begin
                            n_zc = r_zc + 6'd1;
                            if (r_zc == MAX_ZEROS) begin
                                n_outcome = OC_GOLOMB_LONG;
                                n_phase   = PH_DONE;
                            end
                        end else if (r_zc == 6'd0) begin
                            w_push      = 1'b1;
                            w_push_word = '{field_kind: (r_phase == PH_REP_Z) ? K_REP : K_REF,
                                            field_value: 64'd0,
                                            value_unspecified: 1'b0, end_of_run: 1'b0};
                            n_acc = 32'd0;
                            if (r_phase == PH_REP_Z && r_flags[1:0] != 2'd0) begin
                                n_phase = PH_REF_Z;
                            end else begin
                                w_ne = f_next_elem(r_flags, 3'd0);
                                if (w_ne[2]) begin
                                    n_outcome = OC_PARSED;
                                    n_phase   = PH_DONE;
                                end else begin
                                    n_eidx  = w_ne[1:0];
                                    n_phase = PH_SIGN;
                                end
                            end
                        end else begin
                            n_brem  = r_zc;
                            n_acc   = 32'd1;
                            n_phase = (r_phase == PH_REP_Z) ? PH_REP_S : PH_REF_S;
                        end
                    end
                    PH_REP_S, PH_REF_S: begin
                        n_acc  = {r_acc[30:0], w_bit};
                        n_brem = r_brem - 6'd1;
                        if (r_brem == 6'd1) begin
                            w_push      = 1'b1;
                            w_push_word = '{field_kind: (r_phase == PH_REP_S) ? K_REP : K_REF,
                                            field_value: {32'd0, w_gval},
                                            value_unspecified: 1'b0, end_of_run: 1'b0};
                            n_zc  = 6'd0;
                            n_acc = 32'd0;
                            if (r_phase == PH_REP_S && r_flags[1:0] != 2'd0) begin
                                n_phase = PH_REF_Z;
                            end else begin
                                w_ne = f_next_elem(r_flags, 3'd0);
                                if (w_ne[2]) begin
                                    n_outcome = OC_PARSED;
                                    n_phase   = PH_DONE;
                                end else begin
                                    n_eidx  = w_ne[1:0];
                                    n_phase = PH_SIGN;
                                end
                            end
                        end
                    end
                    PH_SIGN: begin
                        n_sign  = w_bit;
                        n_exp   = 7'd0;
                        n_brem  = 6'd7;
                        n_phase = PH_EXP;
                    end
                    PH_EXP: begin
                        n_exp  = {r_exp[5:0], w_bit};
                        n_brem = r_brem - 6'd1;
                        if (r_brem == 6'd1) begin
                            n_mlen  = 6'd0;
                            n_brem  = 6'd5;
                            n_phase = PH_MLEN;
                        end
                    end
                    PH_MLEN: begin
                        n_mlen = {1'b0, r_mlen[3:0], w_bit};
                        n_brem = r_brem - 6'd1;
                        if (r_brem == 6'd1) begin
                            n_mlen  = {1'b0, r_mlen[3:0], w_bit} + 6'd1;
                            n_brem  = {1'b0, r_mlen[3:0], w_bit} + 6'd1;
                            n_mant  = 32'd0;
                            n_phase = PH_MANT;
                        end
                    end
                    PH_MANT: begin
                        n_mant = {r_mant[30:0], w_bit};
                        n_brem = r_brem - 6'd1;
                        if (r_brem == 6'd1) begin
                            w_conv_start = 1'b1;
                            w_ne = f_next_elem(r_flags, {1'b0, r_eidx} + 3'd1);
                            if (w_ne[2]) begin
                                n_outcome = OC_PARSED;
                                n_phase   = PH_DONE;
                            end else begin
                                n_eidx  = w_ne[1:0];
                                n_phase = PH_SIGN;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            SQ_CONV: begin
                if (w_conv_done) begin
                    w_push      = 1'b1;
                    w_push_word = '{field_kind: r_ckind, field_value: w_conv_bits,
                                    value_unspecified: r_cunsp, end_of_run: 1'b0};
                end
            end
            SQ_FIN: begin
                if (r_last) begin
                    w_push      = 1'b1;
                    w_push_word = '{field_kind: K_OUTCOME, field_value: {61'd0, r_outcome},
                                    value_unspecified: 1'b0, end_of_run: 1'b0};
                    n_phase   = PH_LEN;
                    n_bytecnt = 2'd0;
                    n_len     = 32'd0;
                    n_flags   = 4'd0;
                    n_zc      = 6'd0;
                    n_acc     = 32'd0;
                    n_sign    = 1'b0;
                    n_exp     = 7'd0;
                    n_mlen    = 6'd0;
                    n_mant    = 32'd0;
                    n_brem    = 6'd0;
                    n_eidx    = 2'd0;
                    n_outcome = OC_EARLY_END;
                end
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: if (i_in.valid) n_state = SQ_BYTE;
            SQ_BYTE: n_state = w_is_bitphase ? SQ_BITS : SQ_FIN;
            SQ_BITS: begin
                if (w_conv_start) begin
                    n_state = SQ_CONV;
                end else if (r_bitidx == 3'd0 || n_phase == PH_DONE) begin
                    n_state = SQ_FIN;
                end
            end
            SQ_CONV: begin
                if (w_conv_done) begin
                    if (r_bitidx == 3'd0 || r_phase == PH_DONE) n_state = SQ_FIN;
                    else n_state = SQ_BITS;
                end
            end
            SQ_FIN:   n_state = (r_last || r_bcnt != 3'd0) ? SQ_DRAIN : SQ_IDLE;
            SQ_DRAIN: if (w_load && w_rd_last) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SQ_IDLE;
            r_phase   <= PH_LEN;
            r_bytecnt <= 2'd0;
            r_len     <= 32'd0;
            r_flags   <= 4'd0;
            r_zc      <= 6'd0;
            r_acc     <= 32'd0;
            r_sign    <= 1'b0;
            r_exp     <= 7'd0;
            r_mlen    <= 6'd0;
            r_mant    <= 32'd0;
            r_brem    <= 6'd0;
            r_eidx    <= 2'd0;
            r_outcome <= OC_EARLY_END;
            r_bcnt    <= 3'd0;
            r_rd      <= 2'd0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_bytecnt <= n_bytecnt;
            r_len     <= n_len;
            r_flags   <= n_flags;
            r_zc      <= n_zc;
            r_acc     <= n_acc;
            r_sign    <= n_sign;
            r_exp     <= n_exp;
            r_mlen    <= n_mlen;
            r_mant    <= n_mant;
            r_brem    <= n_brem;
            r_eidx    <= n_eidx;
            r_outcome <= n_outcome;
            if (w_push && r_bcnt != 3'd4) begin
                r_bcnt <= r_bcnt + 3'd1;
            end else if (w_load && w_rd_last) begin
                r_bcnt <= 3'd0;
            end
            if (w_load) begin
                r_rd <= w_rd_last ? 2'd0 : r_rd + 2'd1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SQ_IDLE && i_in.valid) begin
            r_data <= i_in.data.data_byte;
            r_last <= i_in.data.last_byte;
        end
        if (r_state == SQ_BYTE) begin
            r_bitidx <= 3'd7;
        end else if (r_state == SQ_BITS && !w_conv_start && r_bitidx != 3'd0) begin
            r_bitidx <= r_bitidx - 3'd1;
        end else if (r_state == SQ_CONV && w_conv_done && r_bitidx != 3'd0) begin
            r_bitidx <= r_bitidx - 3'd1;
        end
        if (w_conv_start) begin
            r_ckind <= K_ZNEAR + {1'b0, r_eidx};
            r_cunsp <= (r_exp == EXP_UNSPEC);
        end
        if (w_push && r_bcnt != 3'd4) begin
            r_buf[r_bcnt[1:0]] <= w_push_word;
        end
        if (w_load) begin
            r_oword <= w_head;
        end
    end
endmodule
`default_nettype wire

/* src/dsei_f64_conv.sv */
// Iterative shift unit converting a depth element into IEEE double bits.
`timescale 1ns / 1ps
`default_nettype none
module dsei_f64_conv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire dsei_pkg::t_conv_req i_req,
    output logic                    o_done,
    output logic [63:0]             o_bits
);
    import dsei_pkg::*;

    t_conv_state r_state, n_state;
    logic [31:0] r_a;
    logic [5:0]  r_cnt;
    logic [6:0]  r_e;
    logic        r_s;
    logic        w_shift;

    // left-align to 32 bits, then normalize on the leading one for a zero exponent
    assign w_shift = !r_cnt[5] || (r_e == 7'd0 && r_a != 32'd0 && !r_a[31]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            CV_IDLE: if (i_start) n_state = CV_RUN;
            CV_RUN:  if (!w_shift) n_state = CV_IDLE;
            default: n_state = CV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == CV_RUN) && !w_shift;
        if (r_e != 7'd0) begin
            o_bits = {r_s, EXP_BIAS_ADJ + {4'd0, r_e}, r_a, 20'd0};
        end else if (r_a == 32'd0) begin
            o_bits = {r_s, 63'd0};
        end else begin
            o_bits = {r_s, 11'(EXP_DENORM - {5'd0, r_cnt}), r_a[30:0], 21'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CV_IDLE && i_start) begin
            r_a   <= i_req.mantissa;
            r_cnt <= i_req.mant_len;
            r_e   <= i_req.exponent;
            r_s   <= i_req.sign;
        end else if (r_state == CV_RUN && w_shift) begin
            r_a   <= {r_a[30:0], 1'b0};
            r_cnt <= r_cnt + 6'd1;
        end
    end
endmodule
`default_nettype wire

/* src/dsei_checker.sv */
// Port-level checks of the SEI parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module dsei_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire dsei_pkg::t_out_word i_out_data
);
    import dsei_pkg::*;

    // a byte in work blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted word");

    a_outcome_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.field_kind == K_OUTCOME |->
            i_out_data.end_of_run && i_out_data.field_value <= 64'(OC_GOLOMB_LONG))
        else $error("outcome word not last or code out of range");

    a_unspec_on_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.value_unspecified |->
            i_out_data.field_kind >= K_ZNEAR && i_out_data.field_kind <= K_DMAX)
        else $error("unspecified flag on a non-depth word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");
endmodule

bind depth_info_sei_parser_core dsei_checker u_dsei_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

/* bench/dsei_field_checker.sv */
// Field checker: predicts the parsed SEI fields per input byte and compares the output words.
`timescale 1ns / 1ps
`default_nettype none
module dsei_field_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsei_in_if        in_ch,
    dsei_out_if       out_ch,
    output int        o_fail_count,
    output int        o_pending
);
    import dsei_pkg::*;

    t_phase      ph;
    logic [2:0]  byte_cnt;
    logic [31:0] len_word;
    logic [3:0]  flags;
    logic [5:0]  zeros;
    logic [31:0] gacc;
    logic        e_sign;
    logic [6:0]  e_exp;
    logic [5:0]  e_len;
    logic [31:0] e_mant;
    logic [5:0]  bits_left;
    logic [1:0]  e_idx;
    logic [2:0]  outcome;

    t_out_word   byte_fields[$];
    t_out_word   parsed_fields_q[$];
    int          fail_cnt = 0;

    task automatic reset_parser();
        ph        = PH_LEN;
        byte_cnt  = '0;
        len_word  = '0;
        flags     = '0;
        zeros     = '0;
        gacc      = '0;
        e_sign    = 1'b0;
        e_exp     = '0;
        e_len     = '0;
        e_mant    = '0;
        bits_left = '0;
        e_idx     = '0;
        outcome   = OC_EARLY_END;
    endtask

    function automatic logic [63:0] elem_to_double(input logic s, input logic [6:0] e,
                                                   input logic [5:0] len_in,
                                                   input logic [31:0] m);
        logic [10:0] ex;
        logic [63:0] frac;
        int          len;
        int          p;
        len = (len_in < 1) ? 1 : (len_in > 32) ? 32 : int'(len_in);
        if (e != 7'd0) begin
            ex   = EXP_BIAS_ADJ + 11'(e);
            frac = 64'(m) << (52 - len);
        end else if (m == 32'd0) begin
            return {s, 63'd0};
        end else begin
            p = 31;
            while (m[p] == 1'b0) p--;
            ex   = 11'(int'(EXP_BIAS_ADJ) + 1 + p - len);
            frac = (64'(m) & ~(64'd1 << p)) << (52 - p);
        end
        return {s, ex, frac[51:0]};
    endfunction

    task automatic emit_field(input logic [2:0] kind, input logic [63:0] value,
                              input logic unspec);
        t_out_word w;
        if (byte_fields.size() < 4) begin
            w.field_kind        = kind;
            w.field_value       = value;
            w.value_unspecified = unspec;
            w.end_of_run        = 1'b0;
            byte_fields = {byte_fields, w};
        end
    endtask

    task automatic finish_parse(input logic [2:0] code);
        outcome = code;
        ph      = PH_DONE;
    endtask

    task automatic seek_element(input logic [2:0] from);
        logic found;
        found = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (!found && j >= from && flags[3 - j]) begin
                found = 1'b1;
                e_idx = 2'(j);
                ph    = PH_SIGN;
            end
        end
        if (!found) finish_parse(OC_PARSED);
    endtask

    task automatic golomb_done(input logic rep, input logic [63:0] value);
        emit_field(rep ? K_REP : K_REF, value, 1'b0);
        zeros = '0;
        gacc  = '0;
        if (rep && flags[1:0] != 2'b00) ph = PH_REF_Z;
        else seek_element(3'd0);
    endtask

    task automatic parse_bit(input logic b);
        logic rep;
        case (ph)
            PH_FLAGS: begin
                flags = {flags[2:0], b};
                bits_left--;
                if (bits_left == 0) begin
                    emit_field(K_FLAGS, {60'd0, flags}, 1'b0);
                    zeros = '0;
                    gacc  = '0;
                    ph    = PH_REP_Z;
                end
            end
            PH_REP_Z, PH_REF_Z: begin
                rep = (ph == PH_REP_Z);
                if (!b) begin
                    zeros++;
                    if (zeros > MAX_ZEROS) finish_parse(OC_GOLOMB_LONG);
                end else if (zeros == 0) begin
                    golomb_done(rep, 64'd0);
                end else begin
                    bits_left = zeros;
                    gacc      = '0;
                    ph        = rep ? PH_REP_S : PH_REF_S;
                end
            end
            PH_REP_S, PH_REF_S: begin
                rep  = (ph == PH_REP_S);
                gacc = {gacc[30:0], b};
                bits_left--;
                if (bits_left == 0)
                    golomb_done(rep, ((64'd1 << zeros) - 64'd1) + 64'(gacc));
            end
            PH_SIGN: begin
                e_sign    = b;
                e_exp     = '0;
                bits_left = 6'd7;
                ph        = PH_EXP;
            end
            PH_EXP: begin
                e_exp = {e_exp[5:0], b};
                bits_left--;
                if (bits_left == 0) begin
                    e_len     = '0;
                    bits_left = 6'd5;
                    ph        = PH_MLEN;
                end
            end
            PH_MLEN: begin
                e_len = {1'b0, e_len[3:0], b};
                bits_left--;
                if (bits_left == 0) begin
                    e_len     = e_len + 6'd1;
                    bits_left = e_len;
                    e_mant    = '0;
                    ph        = PH_MANT;
                end
            end
            PH_MANT: begin
                e_mant = {e_mant[30:0], b};
                bits_left--;
                if (bits_left == 0) begin
                    emit_field(K_ZNEAR + {1'b0, e_idx},
                               elem_to_double(e_sign, e_exp, e_len, e_mant),
                               e_exp == EXP_UNSPEC);
                    seek_element({1'b0, e_idx} + 3'd1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] d);
        case (ph)
            PH_LEN: begin
                len_word = {len_word[23:0], d};
                byte_cnt++;
                if (byte_cnt >= 3'd4) begin
                    byte_cnt = '0;
                    if (len_word <= MIN_LENGTH) finish_parse(OC_SHORT);
                    else ph = PH_NALSIZE;
                end
            end
            PH_NALSIZE: begin
                byte_cnt++;
                if (byte_cnt >= 3'd4) begin
                    byte_cnt = '0;
                    ph       = PH_NALTYPE;
                end
            end
            PH_NALTYPE: begin
                if (d[7:1] == NAL_TYPE_A || d[7:1] == NAL_TYPE_B) ph = PH_SKIP;
                else finish_parse(OC_NOT_SEI);
            end
            PH_SKIP: ph = PH_PID;
            PH_PID: begin
                if (d == DEPTH_PL_TYPE) ph = PH_PSIZE;
                else finish_parse(OC_OTHER_PL);
            end
            PH_PSIZE: begin
                flags     = '0;
                bits_left = 6'd4;
                ph        = PH_FLAGS;
            end
            PH_DONE: ;
            default: begin
                for (int i = 7; i >= 0; i--)
                    if (ph != PH_DONE) parse_bit(d[i]);
            end
        endcase
    endtask

    task automatic predict_fields(input logic [7:0] d, input logic last);
        byte_fields.delete();
        parse_byte(d);
        if (last) begin
            emit_field(K_OUTCOME, {61'd0, outcome}, 1'b0);
            reset_parser();
        end
        if (byte_fields.size() > 0)
            byte_fields[byte_fields.size() - 1].end_of_run = 1'b1;
        foreach (byte_fields[i]) parsed_fields_q = {parsed_fields_q, byte_fields[i]};
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word got;
        t_out_word want;
        logic      bad;
        if (!i_rst_n) begin
            reset_parser();
            parsed_fields_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (parsed_fields_q.size() == 0) begin
                    $error("result word with no prediction: kind %0d value %h",
                           got.field_kind, got.field_value);
                    fail_cnt++;
                end else begin
                    want = parsed_fields_q.pop_front();
                    bad  = 1'b0;
                    if (got.field_kind !== want.field_kind) begin
                        $error("field_kind: expected %0d, got %0d",
                               want.field_kind, got.field_kind);
                        bad = 1'b1;
                    end
                    if (got.field_value !== want.field_value) begin
                        $error("field_value: expected %h, got %h",
                               want.field_value, got.field_value);
                        bad = 1'b1;
                    end
                    if (got.value_unspecified !== want.value_unspecified) begin
                        $error("value_unspecified: expected %b, got %b",
                               want.value_unspecified, got.value_unspecified);
                        bad = 1'b1;
                    end
                    if (got.end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %b, got %b",
                               want.end_of_run, got.end_of_run);
                        bad = 1'b1;
                    end
                    if (bad) fail_cnt++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_fields(in_ch.data.data_byte, in_ch.data.last_byte);
        end
        o_pending    <= parsed_fields_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule
`default_nettype wire

/* bench/depth_info_sei_parser_core_tb.sv */
// Testbench top: builds SEI byte buffers, drives the parser and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module depth_info_sei_parser_core_tb;
    import dsei_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_BYTES = 300;
    localparam int TAIL_CYCLES  = 300;

    logic       i_clk;
    logic       i_rst_n;
    bit         idle_on = 1'b1;
    int         cycle_count = 0;
    int         fail_count;
    int         pending;
    int         sent_bytes;
    bit         sei_bits[$];
    logic [7:0] sei_bytes[$];

    dsei_in_if  in_ch();
    dsei_out_if out_ch();

    depth_info_sei_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dsei_field_checker u_field_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 10);
    end

    task automatic put_bits(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) sei_bits = {sei_bits, v[i]};
    endtask

    task automatic put_golomb(input int zc);
        put_bits(64'd0, zc);
        sei_bits = {sei_bits, 1'b1};
        put_bits(64'($urandom()), zc);
    endtask

    task automatic put_element(input logic s, input logic [6:0] e, input logic [4:0] ml,
                               input logic [31:0] m);
        put_bits(64'(s), 1);
        put_bits(64'(e), 7);
        put_bits(64'(ml), 5);
        put_bits(64'(m), ml + 1);
    endtask

    task automatic put_header(input logic [31:0] len, input logic [6:0] ntype,
                              input logic [7:0] pid);
        put_bits(64'(len), 32);
        put_bits(64'($urandom()), 32);
        put_bits(64'({ntype, 1'($urandom_range(0, 1))}), 8);
        put_bits(64'($urandom_range(0, 255)), 8);
        put_bits(64'(pid), 8);
        put_bits(64'($urandom_range(0, 255)), 8);
    endtask

    function automatic int rand_zeros();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 4);
        if (r < 9) return $urandom_range(5, 16);
        return $urandom_range(17, 31);
    endfunction

    function automatic logic [31:0] rand_length();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = MIN_LENGTH + 32'd1;
            1:       v = '1;
            default: v = $urandom();
        endcase
        if (v <= MIN_LENGTH) v = MIN_LENGTH + 32'd1;
        return v;
    endfunction

    function automatic logic [6:0] bad_nal_type();
        logic [6:0] t;
        do t = 7'($urandom_range(0, 127)); while (t == NAL_TYPE_A || t == NAL_TYPE_B);
        return t;
    endfunction

    function automatic logic [7:0] bad_pl_type();
        logic [7:0] p;
        do p = 8'($urandom_range(0, 255)); while (p == DEPTH_PL_TYPE);
        return p;
    endfunction

    task automatic put_rand_element();
        logic [6:0]  e;
        logic [4:0]  ml;
        logic [31:0] m;
        case ($urandom_range(0, 5))
            0:       e = 7'd0;
            1:       e = EXP_UNSPEC;
            2:       e = 7'd1;
            default: e = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 4))
            0:       ml = 5'd31;
            1:       ml = 5'($urandom_range(0, 31));
            default: ml = 5'($urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 5))
            0:       m = '0;
            1:       m = '1;
            default: m = $urandom();
        endcase
        m = m >> (31 - ml);
        put_element(1'($urandom_range(0, 1)), e, ml, m);
    endtask

    task automatic put_payload(input logic [3:0] fl, input int zc_rep, input int zc_ref);
        put_bits(64'(fl), 4);
        put_golomb(zc_rep);
        if (fl[1:0] != 2'b00) put_golomb(zc_ref);
        for (int i = 3; i >= 0; i--)
            if (fl[i]) put_rand_element();
    endtask

    task automatic send_word(input logic [7:0] d, input logic l);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= {d, l};
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // keep < 0 cuts the buffer at a random byte; extra words follow the buffer
    task automatic send_buffer(input int keep, input int extra);
        int   n;
        logic [7:0] v;
        while (sei_bits.size() % 8 != 0) sei_bits = {sei_bits, 1'($urandom_range(0, 1))};
        for (int i = 0; i < sei_bits.size(); i += 8) begin
            for (int k = 0; k < 8; k++) v[7 - k] = sei_bits[i + k];
            sei_bytes = {sei_bytes, v};
        end
        sei_bits.delete();
        n = sei_bytes.size();
        if (keep < 0) n = $urandom_range(1, n);
        sent_bytes += n + extra;
        for (int i = 0; i < n; i++) send_word(sei_bytes[i], extra == 0 && i == n - 1);
        for (int i = 0; i < extra; i++)
            send_word(8'($urandom_range(0, 255)), i == extra - 1);
        sei_bytes.delete();
    endtask

    task automatic send_random_buffer();
        int         kind;
        int         extra;
        logic [3:0] fl;
        kind  = $urandom_range(0, 99);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        fl    = 4'($urandom_range(0, 15));
        if (kind < 8) begin
            put_bits(64'($urandom_range(0, 4)), 32);
            send_buffer(0, extra);
        end else if (kind < 15) begin
            put_header(rand_length(), bad_nal_type(), DEPTH_PL_TYPE);
            send_buffer(0, extra);
        end else if (kind < 22) begin
            put_header(rand_length(), NAL_TYPE_A, bad_pl_type());
            send_buffer(0, extra);
        end else begin
            put_header(rand_length(), $urandom_range(0, 1) ? NAL_TYPE_A : NAL_TYPE_B,
                       DEPTH_PL_TYPE);
            if (kind < 26) begin
                put_payload(fl, 32 + $urandom_range(0, 3), 0);
            end else if (kind < 30) begin
                put_payload(fl | 4'b0001, rand_zeros(), 32 + $urandom_range(0, 3));
            end else begin
                put_payload(fl, rand_zeros(), rand_zeros());
            end
            if (kind >= 30 && kind < 45) send_buffer(-1, 0);
            else send_buffer(0, extra);
        end
    endtask

    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        i_rst_n      <= 1'b0;
        sent_bytes    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // early end right after reset
        put_bits(64'h00, 8);
        send_buffer(0, 0);
        // length at the rejection bound
        put_bits(64'(MIN_LENGTH), 32);
        send_buffer(0, 0);
        // all-ones header, NAL type out of range
        put_bits('1, 64);
        put_bits(64'hFF, 8);
        send_buffer(0, 0);
        // all fields present, extreme elements, trailing words ignored
        put_bits(64'(MIN_LENGTH + 32'd1), 32);
        put_bits(64'd0, 32);
        put_bits(64'({NAL_TYPE_A, 1'b0}), 8);
        put_bits(64'd0, 8);
        put_bits(64'(DEPTH_PL_TYPE), 8);
        put_bits(64'd0, 8);
        put_bits(64'hF, 4);
        put_golomb(0);
        put_golomb(1);
        put_element(1'b1, 7'd0, 5'd0, 32'd0);
        put_element(1'b0, EXP_UNSPEC, 5'd31, 32'hFFFF_FFFF);
        put_element(1'b0, 7'd0, 5'd4, 32'd1);
        put_element(1'b1, 7'd1, 5'd0, 32'd1);
        send_buffer(0, 2);

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            idle_on = !(sent_bytes >= 150 && sent_bytes < 250);
            send_random_buffer();
        end
        idle_on = 1'b1;
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("depth_info_sei_parser_core_tb: PASS");
        end else begin
            $display("depth_info_sei_parser_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
        $display("depth_info_sei_parser_core_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
